>>> sv/eis_pkg.sv
// Shared types, constants and the operation schedule for the epipolar inlier scorer.
// No dependencies; every other file imports this package.
package eis_pkg;

  localparam int unsigned MAX_PAIRS  = 4096;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned OPND_W     = 31;
  localparam int unsigned PROD_W     = 62;
  localparam int unsigned ACC_W      = 74;
  localparam int unsigned FVEC_W     = 30;
  localparam int unsigned EMAG_W     = 36;
  localparam int unsigned DEN_W      = 61;
  localparam int unsigned SQ_W       = 72;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned NUM_OPS    = 25;
  localparam int unsigned OPCNT_W    = 5;
  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned OUT_DATA_W = 48;

  // Item kinds on tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic REG_SAMPSON_EN = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  // Operand sources of the shared multiplier
  localparam logic [4:0] SRC_E0  = 5'd0;   // E entries 0..8
  localparam logic [4:0] SRC_P1  = 5'd9;   // p1 x,y,z
  localparam logic [4:0] SRC_P2  = 5'd12;  // p2 x,y,z
  localparam logic [4:0] SRC_F1  = 5'd15;  // E*p1 components 0..2
  localparam logic [4:0] SRC_F2  = 5'd18;  // E'*p2 components 0..1
  localparam logic [4:0] SRC_MHI = 5'd20;  // upper 18 bits of |e|
  localparam logic [4:0] SRC_MLO = 5'd21;  // lower 18 bits of |e|

  // Product alignment codes
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_19 = 2'd1;
  localparam logic [1:0] SH_36 = 2'd2;

  // Destinations of a finished sum
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_F1   = 3'd1;
  localparam logic [2:0] DST_F2   = 3'd2;
  localparam logic [2:0] DST_EPI  = 3'd3;
  localparam logic [2:0] DST_DEN  = 3'd4;
  localparam logic [2:0] DST_SQ   = 3'd5;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic [1:0] sh;
    logic       first;
    logic       last;
    logic [2:0] dst;
    logic [1:0] idx;
  } op_t;

  typedef struct packed {
    logic       mul_en;
    logic       acc_en;
    logic       clr;
    logic [1:0] sh;
  } mac_ctrl_t;

  function automatic op_t mk_op(logic [4:0] a, logic [4:0] b, logic [1:0] sh,
                                logic first, logic last, logic [2:0] dst,
                                logic [1:0] idx);
    op_t o;
    o.a_sel = a;
    o.b_sel = b;
    o.sh    = sh;
    o.first = first;
    o.last  = last;
    o.dst   = dst;
    o.idx   = idx;
    return o;
  endfunction

  // Schedule: E*p1, E'*p2 (first two rows), p2.f1, squared norms, |e|^2.
  function automatic op_t op_decode(logic [OPCNT_W-1:0] k);
    op_t o;
    case (k)
      5'd0:  o = mk_op(SRC_E0+5'd0, SRC_P1+5'd0, SH_0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd1:  o = mk_op(SRC_E0+5'd1, SRC_P1+5'd1, SH_0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd2:  o = mk_op(SRC_E0+5'd2, SRC_P1+5'd2, SH_0, 1'b0, 1'b1, DST_F1, 2'd0);
      5'd3:  o = mk_op(SRC_E0+5'd3, SRC_P1+5'd0, SH_0, 1'b1, 1'b0, DST_NONE, 2'd1);
      5'd4:  o = mk_op(SRC_E0+5'd4, SRC_P1+5'd1, SH_0, 1'b0, 1'b0, DST_NONE, 2'd1);
      5'd5:  o = mk_op(SRC_E0+5'd5, SRC_P1+5'd2, SH_0, 1'b0, 1'b1, DST_F1, 2'd1);
      5'd6:  o = mk_op(SRC_E0+5'd6, SRC_P1+5'd0, SH_0, 1'b1, 1'b0, DST_NONE, 2'd2);
      5'd7:  o = mk_op(SRC_E0+5'd7, SRC_P1+5'd1, SH_0, 1'b0, 1'b0, DST_NONE, 2'd2);
      5'd8:  o = mk_op(SRC_E0+5'd8, SRC_P1+5'd2, SH_0, 1'b0, 1'b1, DST_F1, 2'd2);
      5'd9:  o = mk_op(SRC_E0+5'd0, SRC_P2+5'd0, SH_0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd10: o = mk_op(SRC_E0+5'd3, SRC_P2+5'd1, SH_0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd11: o = mk_op(SRC_E0+5'd6, SRC_P2+5'd2, SH_0, 1'b0, 1'b1, DST_F2, 2'd0);
      5'd12: o = mk_op(SRC_E0+5'd1, SRC_P2+5'd0, SH_0, 1'b1, 1'b0, DST_NONE, 2'd1);
      5'd13: o = mk_op(SRC_E0+5'd4, SRC_P2+5'd1, SH_0, 1'b0, 1'b0, DST_NONE, 2'd1);
      5'd14: o = mk_op(SRC_E0+5'd7, SRC_P2+5'd2, SH_0, 1'b0, 1'b1, DST_F2, 2'd1);
      5'd15: o = mk_op(SRC_P2+5'd0, SRC_F1+5'd0, SH_0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd16: o = mk_op(SRC_P2+5'd1, SRC_F1+5'd1, SH_0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd17: o = mk_op(SRC_P2+5'd2, SRC_F1+5'd2, SH_0, 1'b0, 1'b1, DST_EPI, 2'd0);
      5'd18: o = mk_op(SRC_F1+5'd0, SRC_F1+5'd0, SH_0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd19: o = mk_op(SRC_F1+5'd1, SRC_F1+5'd1, SH_0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd20: o = mk_op(SRC_F2+5'd0, SRC_F2+5'd0, SH_0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd21: o = mk_op(SRC_F2+5'd1, SRC_F2+5'd1, SH_0, 1'b0, 1'b1, DST_DEN, 2'd0);
      5'd22: o = mk_op(SRC_MHI, SRC_MHI, SH_36, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd23: o = mk_op(SRC_MHI, SRC_MLO, SH_19, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd24: o = mk_op(SRC_MLO, SRC_MLO, SH_0, 1'b0, 1'b1, DST_SQ, 2'd0);
      default: o = mk_op(SRC_E0, SRC_E0, SH_0, 1'b1, 1'b1, DST_NONE, 2'd0);
    endcase
    return o;
  endfunction

endpackage

>>> sv/epipolar_inlier_scorer.sv
// Top level of the epipolar inlier scorer: sequencer, matrix and point registers,
// result register. Depends on eis_pkg, eis_mac and eis_div.
//
// Scores point pairs against a 3x3 essential matrix E held in registers. A load
// item (tuser = 0) writes one entry of E (index below 9) and clears the inlier
// count; it gives no result. An evaluate item (tuser = 1) gives one result item:
// the Sampson error (p2'Ep1)^2 / (|Ep1|_xy^2 + |E'p2|_xy^2) or the algebraic error
// |p2'Ep1|, unsigned Q12.20 saturated at all ones, an inlier flag (error strictly
// below the threshold, never set for a zero Sampson denominator) and the running
// inlier count, which saturates at 4096 and is kept until the next load item.
// All multiplications go through one shared 31x31 multiply-accumulate unit: 25
// products, each in a multiply state and an accumulate state, then a divider
// start state, a wait on a 32-step restoring divider and a state to post the
// result. An evaluate item keeps s_axis_tready_o low until its result is posted,
// so no new item is taken before the last one is through. The divider finishes
// at once when the quotient overflows or the denominator is zero. The post state
// stretches while the output register still holds an unaccepted result. A
// finished result waits in the output register while the next item is taken.
// Configuration is written through cfg_* (index 0: Sampson mode enable, reset 1;
// index 1: inlier_threshold, reset 0) and is always ready.
module epipolar_inlier_scorer import eis_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // entry_index[3:0], entry_value[27:4], p1_x[51:28], p1_y[75:52], p1_z[99:76],
  // p2_x[123:100], p2_y[147:124], p2_z[171:148], zero fill above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,   // op
  input  logic                  s_axis_tlast_i,   // last_pair
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // error_value[31:0], is_inlier[32], inlier_count[45:33], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,   // set_done
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [ERR_W-1:0]      cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_DIV, S_DWAIT, S_EMIT
  } state_e;

  state_e state_q;

  logic signed [COORD_W-1:0] e_q  [9];
  logic signed [COORD_W-1:0] p1_q [3];
  logic signed [COORD_W-1:0] p2_q [3];
  logic signed [FVEC_W-1:0]  f1_q [3];
  logic signed [FVEC_W-1:0]  f2_q [2];
  logic [EMAG_W-1:0]         emag_q;
  logic [DEN_W-1:0]          den_q;
  logic [SQ_W-1:0]           sq_q;
  logic [OPCNT_W-1:0]        k_q;
  logic                      last_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      sampson_en_q;
  logic [ERR_W-1:0]          thr_q;

  logic                      m_valid_q;
  logic [OUT_DATA_W-1:0]     m_data_q;
  logic                      m_last_q;

  op_t                       op;
  mac_ctrl_t                 mac_ctrl;
  logic signed [OPND_W-1:0]  opa;
  logic signed [OPND_W-1:0]  opb;
  logic signed [ACC_W-1:0]   sum;
  logic signed [EMAG_W-1:0]  epi;
  logic                      div_start;
  logic                      div_done;
  logic                      div_sat;
  logic [ERR_W-1:0]          div_quo;
  logic                      in_acc;
  logic                      out_free;
  logic [ERR_W-1:0]          err;
  logic                      inlier;
  logic [CNT_W-1:0]          cnt_next;
  logic [3:0]                ld_idx;

  // Pick one multiplier operand by source code.
  function automatic logic signed [OPND_W-1:0] pick(
    logic [4:0] sel,
    logic signed [COORD_W-1:0] e [9],
    logic signed [COORD_W-1:0] p1 [3],
    logic signed [COORD_W-1:0] p2 [3],
    logic signed [FVEC_W-1:0]  f1 [3],
    logic signed [FVEC_W-1:0]  f2 [2],
    logic [EMAG_W-1:0]         em
  );
    logic signed [OPND_W-1:0] v;
    case (sel)
      SRC_E0+5'd0: v = OPND_W'(e[0]);
      SRC_E0+5'd1: v = OPND_W'(e[1]);
      SRC_E0+5'd2: v = OPND_W'(e[2]);
      SRC_E0+5'd3: v = OPND_W'(e[3]);
      SRC_E0+5'd4: v = OPND_W'(e[4]);
      SRC_E0+5'd5: v = OPND_W'(e[5]);
      SRC_E0+5'd6: v = OPND_W'(e[6]);
      SRC_E0+5'd7: v = OPND_W'(e[7]);
      SRC_E0+5'd8: v = OPND_W'(e[8]);
      SRC_P1+5'd0: v = OPND_W'(p1[0]);
      SRC_P1+5'd1: v = OPND_W'(p1[1]);
      SRC_P1+5'd2: v = OPND_W'(p1[2]);
      SRC_P2+5'd0: v = OPND_W'(p2[0]);
      SRC_P2+5'd1: v = OPND_W'(p2[1]);
      SRC_P2+5'd2: v = OPND_W'(p2[2]);
      SRC_F1+5'd0: v = OPND_W'(f1[0]);
      SRC_F1+5'd1: v = OPND_W'(f1[1]);
      SRC_F1+5'd2: v = OPND_W'(f1[2]);
      SRC_F2+5'd0: v = OPND_W'(f2[0]);
      SRC_F2+5'd1: v = OPND_W'(f2[1]);
      SRC_MHI:     v = signed'(OPND_W'(em[EMAG_W-1:18]));
      SRC_MLO:     v = signed'(OPND_W'(em[17:0]));
      default:     v = '0;
    endcase
    return v;
  endfunction

  assign op = op_decode(k_q);

  always_comb begin
    opa = pick(op.a_sel, e_q, p1_q, p2_q, f1_q, f2_q, emag_q);
    opb = pick(op.b_sel, e_q, p1_q, p2_q, f1_q, f2_q, emag_q);
    mac_ctrl.mul_en = state_q == S_MUL;
    mac_ctrl.acc_en = state_q == S_ACC;
    mac_ctrl.clr    = op.first;
    mac_ctrl.sh     = op.sh;
  end

  eis_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (opa),
    .b_i    (opb),
    .sum_o  (sum)
  );

  assign div_start = state_q == S_DIV;

  // Numerator is |e|^2 * 2^20; split into the part above bit 31 and the rest.
  eis_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (DEN_W'(sq_q[SQ_W-1:12])),
    .num_lo_i ({sq_q[11:0], 20'd0}),
    .den_i    (den_q),
    .done_o   (div_done),
    .sat_o    (div_sat),
    .quo_o    (div_quo)
  );

  assign s_axis_tready_o = state_q == S_IDLE;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign ld_idx          = s_axis_tdata_i[3:0];
  assign epi             = sum[55:20];   // floor to Q.20

  // Final error, inlier decision and updated count.
  always_comb begin
    if (!sampson_en_q) begin
      err = (emag_q[EMAG_W-1:ERR_W] != '0) ? '1 : emag_q[ERR_W-1:0];
    end else if (den_q == '0 || div_sat) begin
      err = '1;
    end else begin
      err = div_quo;
    end
    inlier   = (err < thr_q) && !(sampson_en_q && den_q == '0);
    cnt_next = (inlier && cnt_q < CNT_W'(MAX_PAIRS)) ? cnt_q + 1'b1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= '0;
      cnt_q        <= '0;
      sampson_en_q <= 1'b1;
      thr_q        <= '0;
      m_valid_q    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        e_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SAMPSON_EN: sampson_en_q <= cfg_data_i[0];
          REG_THRESHOLD:  thr_q        <= cfg_data_i;
          default:        ;
        endcase
      end
      // post a new result or drop the accepted one
      if (state_q == S_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser_i == OP_LOAD) begin
              if (ld_idx < 4'd9) begin
                e_q[ld_idx] <= s_axis_tdata_i[27:4];
              end
              cnt_q <= '0;
            end else begin
              k_q     <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (k_q == OPCNT_W'(NUM_OPS - 1)) begin
            state_q <= S_DIV;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_DIV:   state_q <= S_DWAIT;
        S_DWAIT: if (div_done) state_q <= S_EMIT;
        S_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            cnt_q   <= cnt_next;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser_i == OP_EVAL) begin
      p1_q[0] <= s_axis_tdata_i[51:28];
      p1_q[1] <= s_axis_tdata_i[75:52];
      p1_q[2] <= s_axis_tdata_i[99:76];
      p2_q[0] <= s_axis_tdata_i[123:100];
      p2_q[1] <= s_axis_tdata_i[147:124];
      p2_q[2] <= s_axis_tdata_i[171:148];
      last_q  <= s_axis_tlast_i;
    end
    if (state_q == S_ACC && op.last) begin
      case (op.dst)
        DST_F1:  f1_q[op.idx] <= sum[49:20];
        DST_F2:  f2_q[op.idx[0]] <= sum[49:20];
        DST_EPI: emag_q <= epi[EMAG_W-1] ? EMAG_W'(-epi) : EMAG_W'(epi);
        DST_DEN: den_q  <= sum[DEN_W-1:0];
        DST_SQ:  sq_q   <= sum[SQ_W-1:0];
        default: ;
      endcase
    end
    if (state_q == S_EMIT && out_free) begin
      m_data_q <= {2'b00, cnt_next, inlier, err};
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

>>> sv/eis_mac.sv
// Shared multiply-accumulate unit: one registered 31x31 signed product, then an
// aligned add into a 74-bit accumulator. Depends on eis_pkg.
module eis_mac import eis_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [OPND_W-1:0] a_i,
  input  logic signed [OPND_W-1:0] b_i,
  output logic signed [ACC_W-1:0]  sum_o
);

  logic signed [PROD_W-1:0] mul_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  prod_al;

  always_comb begin
    prod_ext = ACC_W'(mul_q);
    case (ctrl_i.sh)
      SH_19:   prod_al = prod_ext <<< 19;
      SH_36:   prod_al = prod_ext <<< 36;
      default: prod_al = prod_ext;
    endcase
    sum_o = (ctrl_i.clr ? '0 : acc_q) + prod_al;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
      acc_q <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        mul_q <= a_i * b_i;
      end
      if (ctrl_i.acc_en) begin
        acc_q <= sum_o;
      end
    end
  end

endmodule

>>> sv/eis_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit saturating quotient.
// Depends on eis_pkg.
module eis_div import eis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DEN_W-1:0]   num_hi_i,
  input  logic [ERR_W-1:0]   num_lo_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic               sat_o,
  output logic [ERR_W-1:0]   quo_o
);

  logic             busy_q;
  logic             done_q;
  logic             sat_q;
  logic [4:0]       cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [ERR_W-1:0] num_q;
  logic [ERR_W-1:0] quo_q;
  logic [DEN_W:0]   rem2;
  logic             take;

  always_comb begin
    rem2 = {rem_q, num_q[ERR_W-1]};
    take = rem2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // quotient overflows 32 bits when the high part already reaches den
        sat_q  <= num_hi_i >= den_i;
        busy_q <= num_hi_i < den_i;
        done_q <= num_hi_i >= den_i;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi_i;
      den_q <= den_i;
      num_q <= num_lo_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DEN_W'(rem2 - {1'b0, den_q}) : DEN_W'(rem2);
      num_q <= {num_q[ERR_W-2:0], 1'b0};
      quo_q <= {quo_q[ERR_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign sat_o  = sat_q;
  assign quo_o  = quo_q;

endmodule

>>> tb/epipolar_inlier_scorer_tb.sv
// Self-checking testbench for the epipolar inlier scorer: load items update a
// predictor in this file, which scores each evaluate item; results are compared
// field by field. Depends on eis_pkg and the epipolar_inlier_scorer RTL.
module epipolar_inlier_scorer_tb;
  import eis_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic [31:0] err;
    logic        inlier;
    logic [12:0] count;
    logic        done;
  } score_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  s_axis_tlast_i = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i = 1'b0;
  logic [ERR_W-1:0]      cfg_data_i = '0;

  epipolar_inlier_scorer uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state, kept apart from the block.
  logic [23:0] mat_q[9];
  logic [12:0] count_q;
  logic        sampson_q;
  logic [31:0] thresh_q;

  score_t      pend_mem[64];     // predictions waiting for their result
  int unsigned n_pred = 0;
  int unsigned n_got = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;      // no idling in the last part
  bit          hold_rx = 1'b0;   // long receiver stall requested

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  // Arithmetic right shift by 20 floors toward minus infinity.
  function automatic longint fl20(longint v);
    return v >>> 20;
  endfunction

  function automatic score_t score_pair(logic [23:0] p[6], logic last);
    longint f1[3], f2[3], s1, s2, ep;
    logic [63:0] em, d;
    logic [127:0] num, q;
    score_t r;
    bit inl;
    for (int i = 0; i < 3; i++) begin
      s1 = 0; s2 = 0;
      for (int j = 0; j < 3; j++) begin
        s1 += sx24(mat_q[i*3+j]) * sx24(p[j]);
        s2 += sx24(mat_q[j*3+i]) * sx24(p[3+j]);
      end
      f1[i] = fl20(s1);
      f2[i] = fl20(s2);
    end
    ep = 0;
    for (int i = 0; i < 3; i++) ep += sx24(p[3+i]) * f1[i];
    ep = fl20(ep);
    em = (ep < 0) ? 64'(-ep) : 64'(ep);
    if (sampson_q) begin
      d = 64'(f1[0]*f1[0]) + 64'(f1[1]*f1[1]) + 64'(f2[0]*f2[0]) + 64'(f2[1]*f2[1]);
      if (d == 0) begin
        r.err = '1;
        inl = 1'b0;
      end else begin
        num = (128'(em) * 128'(em)) << 20;
        q = num / 128'(d);
        r.err = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        inl = r.err < thresh_q;
      end
    end else begin
      r.err = (em > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : em[31:0];
      inl = r.err < thresh_q;
    end
    if (inl && count_q < MAX_PAIRS) count_q++;
    r.inlier = inl;
    r.count = count_q;
    r.done = last;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
    n_errors++;
  endtask

  // Sometimes drop valid for a random burst of idle cycles.
  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Offer one item and hold it until accepted; predict on acceptance.
  // Valid stays high after acceptance until the next gap or drain.
  task automatic send_item(logic op, logic [3:0] idx, logic [23:0] val,
                           logic [23:0] p[6], logic last);
    logic [IN_DATA_W-1:0] d;
    idle_gap();
    d = '0;
    d[3:0] = idx;
    d[27:4] = val;
    for (int k = 0; k < 6; k++) d[28+24*k +: 24] = p[k];
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= op;
    s_axis_tlast_i  <= last;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op == OP_LOAD) begin
      if (idx < 9) mat_q[idx] = val;
      count_q = '0;
    end else begin
      pend_mem[n_pred[5:0]] = score_pair(p, last);
      n_pred++;
    end
  endtask

  task automatic load_entry(logic [3:0] idx, logic [23:0] val);
    logic [23:0] p[6];
    foreach (p[k]) p[k] = 24'($urandom);
    send_item(OP_LOAD, idx, val, p, 1'b0);
  endtask

  task automatic eval_pair(logic [23:0] p[6], logic last);
    send_item(OP_EVAL, 4'($urandom), 24'($urandom), p, last);
  endtask

  function automatic logic [23:0] rnd_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 2097152)) - 24'sd1048576);
      default: return 24'($signed($urandom_range(0, 4096)) - 24'sd2048);
    endcase
  endfunction

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (n_pred != n_got) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SAMPSON_EN) sampson_q = val[0];
    else thresh_q = val;
  endtask

  task automatic load_random_matrix(int mode);
    for (int i = 0; i < 9; i++) load_entry(4'(i), rnd_coord(mode));
  endtask

  // Extremes of every field, both modes, zero denominator, bad index, last flag.
  task automatic test_directed();
    logic [23:0] p[6];
    foreach (p[k]) p[k] = 24'h7FFFFF;
    eval_pair(p, 1'b1);                       // zero matrix: zero denominator
    for (int i = 0; i < 9; i++) load_entry(4'(i), (i % 2) ? 24'h800000 : 24'h7FFFFF);
    eval_pair(p, 1'b0);
    foreach (p[k]) p[k] = 24'h800000;
    eval_pair(p, 1'b1);
    load_entry(4'hF, 24'h123456);             // out-of-range index clears count
    foreach (p[k]) p[k] = 24'h100000;
    eval_pair(p, 1'b0);
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    eval_pair(p, 1'b0);
    write_reg(REG_SAMPSON_EN, 1'b0);
    foreach (p[k]) p[k] = 24'h7FFFFF;
    eval_pair(p, 1'b1);
    foreach (p[k]) p[k] = 24'h000000;
    eval_pair(p, 1'b0);
    write_reg(REG_THRESHOLD, 32'h0);
    eval_pair(p, 1'b0);
    write_reg(REG_SAMPSON_EN, 1'b1);
  endtask

  // Hypotheses with random content, occasional stray loads as noise.
  task automatic test_random(int n_items);
    int sent = 0;
    logic [23:0] p[6];
    int mode, set_len;
    while (sent < n_items) begin
      mode = $urandom_range(0, 2);
      load_random_matrix(mode);
      sent += 9;
      set_len = $urandom_range(3, 40);
      for (int k = 0; k < set_len && sent < n_items; k++) begin
        if ($urandom_range(0, 30) == 0) begin
          load_entry(4'($urandom), rnd_coord(mode));
        end else begin
          foreach (p[m]) p[m] = rnd_coord(mode);
          eval_pair(p, k == set_len - 1);
        end
        sent++;
      end
    end
  endtask

  // Long run of inliers under a huge threshold, count climbing steadily.
  task automatic test_inlier_run();
    logic [23:0] p[6];
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_SAMPSON_EN, 1'b0);
    load_random_matrix(2);
    for (int k = 0; k < 560; k++) begin
      foreach (p[m]) p[m] = rnd_coord(2);
      eval_pair(p, k == 559);
    end
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    logic [23:0] p[6];
    hold_rx = 1'b1;
    for (int k = 0; k < 6; k++) begin
      foreach (p[m]) p[m] = rnd_coord(1);
      eval_pair(p, 1'b0);
    end
    hold_rx = 1'b0;
    drain();                                  // sender pause until all results are in
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long counted hold-off when asked.
  initial begin : rx_stall
    int hold;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready_i <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
        while (hold_rx) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (n_pred == n_got) begin
        report("unexpected result", m_axis_tdata_o, 0);
      end else begin
        want = pend_mem[n_got[5:0]];
        n_got++;
        if (m_axis_tdata_o[31:0] !== want.err) report("error_value", m_axis_tdata_o[31:0], want.err);
        if (m_axis_tdata_o[32] !== want.inlier) report("is_inlier", m_axis_tdata_o[32], want.inlier);
        if (m_axis_tdata_o[45:33] !== want.count) report("inlier_count", m_axis_tdata_o[45:33], want.count);
        if (m_axis_tlast_o !== want.done) report("set_done", m_axis_tlast_o, want.done);
      end
    end
  end

  initial begin
    foreach (mat_q[i]) mat_q[i] = '0;
    count_q = '0;
    sampson_q = 1'b1;
    thresh_q = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(REG_THRESHOLD, 32'h0000_4000);
    test_random(550);
    test_backpressure();
    write_reg(REG_SAMPSON_EN, 1'b0);
    write_reg(REG_THRESHOLD, 32'h0010_0000);
    test_random(500);
    test_inlier_run();
    write_reg(REG_SAMPSON_EN, 1'b1);
    write_reg(REG_THRESHOLD, 32'h8000_0000);
    calm = 1'b1;
    test_random(300);
    drain();
    if (n_errors == 0 && n_pred == n_got) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
